[sv/sseu_pkg.sv]
// ----------------------------------------------------------------------------
// sseu_pkg: stack script execute unit shared definitions
// Token codes, result codes and print kinds.
// ----------------------------------------------------------------------------
package sseu_pkg;

	localparam logic [4:0] OP_PUSH   = 5'd0;
	localparam logic [4:0] OP_SWAP   = 5'd1;
	localparam logic [4:0] OP_DUP    = 5'd2;
	localparam logic [4:0] OP_DROP   = 5'd3;
	localparam logic [4:0] OP_ADD    = 5'd4;
	localparam logic [4:0] OP_SUB    = 5'd5;
	localparam logic [4:0] OP_MUL    = 5'd6;
	localparam logic [4:0] OP_DIV    = 5'd7;
	localparam logic [4:0] OP_MOD    = 5'd8;
	localparam logic [4:0] OP_EQ     = 5'd9;
	localparam logic [4:0] OP_NE     = 5'd10;
	localparam logic [4:0] OP_GE     = 5'd11;
	localparam logic [4:0] OP_LE     = 5'd12;
	localparam logic [4:0] OP_LT     = 5'd13;
	localparam logic [4:0] OP_GT     = 5'd14;
	localparam logic [4:0] OP_PRINT  = 5'd15;
	localparam logic [4:0] OP_LABEL  = 5'd16;
	localparam logic [4:0] OP_GOTO   = 5'd17;
	localparam logic [4:0] OP_IFGOTO = 5'd18;
	localparam logic [4:0] OP_LOOP   = 5'd19;
	localparam logic [4:0] OP_HEX    = 5'd20;
	localparam logic [4:0] OP_DEC    = 5'd21;
	localparam logic [4:0] OP_MODE   = 5'd22;
	localparam logic [4:0] OP_QUIT   = 5'd23;

	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_DIV0  = 2'd1;
	localparam logic [1:0] ERR_RANGE = 2'd2;
	localparam logic [1:0] ERR_UNSET = 2'd3;

	localparam logic [2:0] KIND_DEC     = 3'd0;
	localparam logic [2:0] KIND_HEXLONG = 3'd3;
	localparam logic [2:0] KIND_CHAR    = 3'd4;

	typedef struct packed {
		logic       halt;
		logic       hex_mode;
		logic [1:0] error_code;
		logic [9:0] jump_target;
		logic       jump_taken;
		logic [2:0] print_kind;
		logic [31:0] print_value;
		logic       print_valid;
	} result_t;

endpackage

[sv/stack_script_execute_unit.sv]
// ----------------------------------------------------------------------------
// stack_script_execute_unit: token executor on a shift-register stack
// ----------------------------------------------------------------------------
// Usage:
//  s_tvalid/s_tready/s_tdata take one token word: operation, literal,
//  print format and script position. m_tvalid/m_tready/m_tdata return one
//  result word per token (print, jump, error, mode and halt fields).
//  A single shared 32-bit adder/subtractor does the add, sub, compares,
//  loop decrement and every step of the restoring divider; multiply uses
//  one 32x32 multiplier with a register on its output.
//  Most tokens go from acceptance through execute to the result register;
//  mul adds the multiplier output register; div and mod go through setup,
//  32 shift-subtract steps and a sign fix with write back, unless the
//  divisor is zero, when they finish like most tokens. The block takes one
//  token at a time: s_tready rises again the cycle after the receiver has
//  taken the result word.
//  Reset clears the stack, label valid bits and hex mode. Label positions
//  are not cleared; they are only read behind their valid bit.
//  While the receiver stalls, hold the result word in the output register
//  and accept no further token.
// ----------------------------------------------------------------------------
module stack_script_execute_unit #(
	parameter int STACK_DEPTH  = 10,
	parameter int LABEL_COUNT  = 10,
	parameter int PROGRAM_SIZE = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// operation[4:0], literal_value[36:5], print_format[39:37],
	// program_position[49:40], zero fill to 56 bits
	input  logic [55:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// print_valid[0], print_value[32:1], print_kind[35:33], jump_taken[36],
	// jump_target[46:37], error_code[48:47], hex_mode[49], halt[50], zero fill
	output logic [55:0] m_tdata
);

	localparam int LW = (LABEL_COUNT > 1) ? $clog2(LABEL_COUNT) : 1;
	localparam int TOP = STACK_DEPTH - 1;
	localparam int NXT = STACK_DEPTH - 2;
	localparam logic [16:0] PSIZE = 17'(PROGRAM_SIZE);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXEC = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_FIX  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0]  state_q;
	logic [31:0] stack_q [STACK_DEPTH];
	logic [9:0]  lpos_q  [LABEL_COUNT];
	logic [LABEL_COUNT-1:0] ldef_q;
	logic        hex_q;
	logic [4:0]  op_q;
	logic [31:0] lit_q;
	logic [2:0]  fmt_q;
	logic [9:0]  pos_q;
	logic [31:0] prod_q;
	logic [31:0] rem_q, quo_q, dvs_q;
	logic [5:0]  cnt_q;
	logic        qneg_q, rneg_q;
	sseu_pkg::result_t res_q;
	sseu_pkg::result_t res_d;
	logic        out_v_q;
	logic        div_go;
	logic        lab_ok;
	logic [1:0]  lk_a, lk_b;

	logic [31:0] a, b;
	assign a = stack_q[NXT];
	assign b = stack_q[TOP];

	// Shared adder: operands chosen by state and operation
	logic [31:0] add_x, add_y;
	logic        add_sub;
	logic [32:0] add_r;
	always_comb begin
		add_x = a;
		add_y = b;
		add_sub = 1'b1;
		if (state_q == ST_DIV) begin
			add_x = {rem_q[30:0], quo_q[31]};
			add_y = dvs_q;
		end else if (state_q == ST_FIX) begin
			add_x = 32'd0;
			add_y = (op_q == sseu_pkg::OP_DIV) ? quo_q : rem_q;
		end else if (op_q == sseu_pkg::OP_ADD) begin
			add_sub = 1'b0;
		end else if (op_q == sseu_pkg::OP_LOOP) begin
			add_y = 32'd1;
		end
		add_r = add_sub ? ({1'b0, add_x} + {1'b0, ~add_y} + 33'd1)
			: ({1'b0, add_x} + {1'b0, add_y});
	end

	// Signed compare from the subtractor
	logic eq_f, lt_f;
	assign eq_f = (a == b);
	assign lt_f = (a[31] != b[31]) ? a[31] : add_r[31];

	// Label lookup
	function automatic logic [1:0] lk_err(input logic [31:0] v,
		input logic [LABEL_COUNT-1:0] d);
		logic [1:0] e;
		e = sseu_pkg::ERR_NONE;
		if (v[31] || v >= 32'(LABEL_COUNT)) e = sseu_pkg::ERR_RANGE;
		else if (!d[v[LW-1:0]]) e = sseu_pkg::ERR_UNSET;
		return e;
	endfunction

	assign lk_a   = lk_err(a, ldef_q);
	assign lk_b   = lk_err(b, ldef_q);
	assign lab_ok = !b[31] && (b < 32'(LABEL_COUNT));
	assign div_go = ((op_q == sseu_pkg::OP_DIV) || (op_q == sseu_pkg::OP_MOD))
		&& (b != 32'd0);

	logic [16:0] pos_sat;
	assign pos_sat = ({7'd0, pos_q} > PSIZE) ? PSIZE : {7'd0, pos_q};

	// Result word of the token in execute
	always_comb begin
		res_d = '0;
		unique case (op_q)
			sseu_pkg::OP_PRINT: begin
				res_d.print_valid = 1'b1;
				res_d.print_value = b;
				if (fmt_q >= 3'd1 && fmt_q <= sseu_pkg::KIND_CHAR)
					res_d.print_kind = fmt_q;
				else
					res_d.print_kind = hex_q ? sseu_pkg::KIND_HEXLONG : sseu_pkg::KIND_DEC;
			end
			sseu_pkg::OP_LABEL: begin
				if (!lab_ok) res_d.error_code = sseu_pkg::ERR_RANGE;
			end
			sseu_pkg::OP_GOTO: begin
				res_d.error_code = lk_b;
				if (lk_b == sseu_pkg::ERR_NONE) begin
					res_d.jump_taken  = 1'b1;
					res_d.jump_target = lpos_q[b[LW-1:0]];
				end
			end
			sseu_pkg::OP_IFGOTO: begin
				// False condition: skip the label check
				if (b != 32'd0) begin
					res_d.error_code = lk_a;
					if (lk_a == sseu_pkg::ERR_NONE) begin
						res_d.jump_taken  = 1'b1;
						res_d.jump_target = lpos_q[a[LW-1:0]];
					end
				end
			end
			sseu_pkg::OP_LOOP: begin
				if (add_r[31:0] != 32'd0) begin
					res_d.error_code = lk_b;
					if (lk_b == sseu_pkg::ERR_NONE) begin
						res_d.jump_taken  = 1'b1;
						res_d.jump_target = lpos_q[b[LW-1:0]];
					end
				end
			end
			sseu_pkg::OP_DIV, sseu_pkg::OP_MOD: begin
				if (b == 32'd0) res_d.error_code = sseu_pkg::ERR_DIV0;
			end
			sseu_pkg::OP_QUIT: res_d.halt = 1'b1;
			default: ;
		endcase
		unique case (op_q)
			sseu_pkg::OP_HEX: res_d.hex_mode = 1'b1;
			sseu_pkg::OP_DEC: res_d.hex_mode = 1'b0;
			default:          res_d.hex_mode = hex_q;
		endcase
	end

	assign s_tready = (state_q == ST_IDLE) && !out_v_q;
	assign m_tvalid = out_v_q;
	assign m_tdata  = {5'd0, res_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int i = 0; i < STACK_DEPTH; i++) stack_q[i] <= 32'd0;
			ldef_q  <= '0;
			hex_q   <= 1'b0;
			out_v_q <= 1'b0;
			cnt_q   <= 6'd0;
		end else begin
			if (out_v_q && m_tready) out_v_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid && s_tready) begin
						op_q  <= s_tdata[4:0];
						lit_q <= s_tdata[36:5];
						fmt_q <= s_tdata[39:37];
						pos_q <= s_tdata[49:40];
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					// Register the result word; mul and div with a nonzero divisor send it later
					res_q   <= res_d;
					out_v_q <= !((op_q == sseu_pkg::OP_MUL) || div_go);
					if (op_q == sseu_pkg::OP_MUL) state_q <= ST_MUL;
					else if (div_go) state_q <= ST_DIV;
					else state_q <= ST_IDLE;
					unique case (op_q)
						sseu_pkg::OP_PUSH, sseu_pkg::OP_DUP: begin
							for (int i = 0; i < TOP; i++) stack_q[i] <= stack_q[i+1];
							stack_q[TOP] <= (op_q == sseu_pkg::OP_PUSH) ? lit_q : b;
						end
						sseu_pkg::OP_SWAP: begin
							stack_q[NXT] <= b;
							stack_q[TOP] <= a;
						end
						sseu_pkg::OP_DROP, sseu_pkg::OP_PRINT, sseu_pkg::OP_LABEL,
						sseu_pkg::OP_GOTO: begin
							for (int i = 1; i <= TOP; i++) stack_q[i] <= stack_q[i-1];
							if (op_q == sseu_pkg::OP_LABEL && lab_ok) begin
								lpos_q[b[LW-1:0]] <= pos_sat[9:0];
								ldef_q[b[LW-1:0]] <= 1'b1;
							end
						end
						sseu_pkg::OP_IFGOTO: begin
							for (int i = 2; i <= TOP; i++) stack_q[i] <= stack_q[i-2];
							stack_q[1] <= stack_q[0];
						end
						sseu_pkg::OP_LOOP: begin
							if (add_r[31:0] == 32'd0) begin
								for (int i = 2; i <= TOP; i++) stack_q[i] <= stack_q[i-2];
								stack_q[1] <= stack_q[0];
							end else begin
								for (int i = 1; i < TOP; i++) stack_q[i] <= stack_q[i-1];
								stack_q[TOP] <= add_r[31:0];
							end
						end
						sseu_pkg::OP_ADD, sseu_pkg::OP_SUB, sseu_pkg::OP_EQ,
						sseu_pkg::OP_NE, sseu_pkg::OP_GE, sseu_pkg::OP_LE,
						sseu_pkg::OP_LT, sseu_pkg::OP_GT: begin
							for (int i = 1; i < TOP; i++) stack_q[i] <= stack_q[i-1];
							unique case (op_q)
								sseu_pkg::OP_ADD, sseu_pkg::OP_SUB:
									stack_q[TOP] <= add_r[31:0];
								sseu_pkg::OP_EQ: stack_q[TOP] <= {31'd0, eq_f};
								sseu_pkg::OP_NE: stack_q[TOP] <= {31'd0, !eq_f};
								sseu_pkg::OP_GE: stack_q[TOP] <= {31'd0, !lt_f};
								sseu_pkg::OP_LE: stack_q[TOP] <= {31'd0, lt_f || eq_f};
								sseu_pkg::OP_LT: stack_q[TOP] <= {31'd0, lt_f};
								default:         stack_q[TOP] <= {31'd0, !lt_f && !eq_f};
							endcase
						end
						sseu_pkg::OP_MUL: prod_q <= a * b;
						sseu_pkg::OP_DIV, sseu_pkg::OP_MOD: begin
							if (b == 32'd0) begin
								// Keep the divisor on top, drop the second entry
								for (int i = 1; i < TOP; i++) stack_q[i] <= stack_q[i-1];
							end else begin
								// Set up magnitude division
								rem_q  <= 32'd0;
								quo_q  <= a[31] ? (~a + 32'd1) : a;
								dvs_q  <= b[31] ? (~b + 32'd1) : b;
								qneg_q <= a[31] ^ b[31];
								rneg_q <= a[31];
								cnt_q  <= 6'd32;
							end
						end
						sseu_pkg::OP_HEX: hex_q <= 1'b1;
						sseu_pkg::OP_DEC: hex_q <= 1'b0;
						default: ;
					endcase
				end
				ST_MUL: begin
					for (int i = 1; i < TOP; i++) stack_q[i] <= stack_q[i-1];
					stack_q[TOP] <= prod_q;
					out_v_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_DIV: begin
					// One restoring step: shift in next dividend bit, try subtract
					if (add_r[32]) begin
						rem_q <= add_r[31:0];
						quo_q <= {quo_q[30:0], 1'b1};
					end else begin
						rem_q <= {rem_q[30:0], quo_q[31]};
						quo_q <= {quo_q[30:0], 1'b0};
					end
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) state_q <= ST_FIX;
				end
				ST_FIX: begin
					for (int i = 1; i < TOP; i++) stack_q[i] <= stack_q[i-1];
					if (op_q == sseu_pkg::OP_DIV)
						stack_q[TOP] <= qneg_q ? add_r[31:0] : quo_q;
					else
						stack_q[TOP] <= rneg_q ? add_r[31:0] : rem_q;
					out_v_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
